@@ hw/rtl/tpme_pkg.sv @@
package tpme_pkg;

    // tour size and field widths
    localparam int NUM_CITIES = 64;
    localparam int IDX_W      = $clog2(NUM_CITIES);
    localparam int POS_W      = 6;
    localparam int CITY_W     = 6;
    // one bit above the wider of index and position so the tour size itself fits
    localparam int EXT_W      = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [CITY_W-1:0] t_city;

    typedef enum logic [1:0] {
        OP_SWAP    = 2'd0,
        OP_REVERSE = 2'd1,
        OP_ROTATE  = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    // classified request handed from front to back
    typedef struct packed {
        t_op  op;
        t_idx lo;
        t_idx hi;
        logic reject;
    } t_cmd;

    typedef struct packed {
        t_city city;
        logic  status;
    } t_res;

    // tour memory access for one cycle
    typedef struct packed {
        logic re_a;
        t_idx addr_a;
        logic re_b;
        t_idx addr_b;
        logic we;
        t_idx waddr;
        t_idx wdata;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WLO,
        S_WHI,
        S_SHIFT,
        S_TAIL,
        S_DONE
    } t_state;

    // stored city number masked to the output field
    function automatic t_city city_field(input t_idx v);
        logic [EXT_W-1:0] w;
        w = EXT_W'(v);
        return w[CITY_W-1:0];
    endfunction

    // position widened so it can be checked against the tour size
    function automatic logic [EXT_W-1:0] pos_ext(input t_pos p);
        return EXT_W'(p);
    endfunction

endpackage

@@ hw/rtl/tpme_tour_mem.sv @@
module tpme_tour_mem
    import tpme_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_idx     o_data_a,
    output t_idx     o_data_b
);

    t_idx                  r_mem [NUM_CITIES];
    logic [NUM_CITIES-1:0] r_vld;
    t_idx                  r_da;
    t_idx                  r_db;
    t_idx                  r_aa;
    t_idx                  r_ab;
    logic                  r_va;
    logic                  r_vb;

    // valid bits: an entry never written reads as its own index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re_a) begin
            r_da <= r_mem[i_req.addr_a];
            r_va <= r_vld[i_req.addr_a];
            r_aa <= i_req.addr_a;
        end
        if (i_req.re_b) begin
            r_db <= r_mem[i_req.addr_b];
            r_vb <= r_vld[i_req.addr_b];
            r_ab <= i_req.addr_b;
        end
    end

    assign o_data_a = r_va ? r_da : r_aa;
    assign o_data_b = r_vb ? r_db : r_ab;

endmodule

@@ hw/rtl/tpme_front.sv @@
module tpme_front
    import tpme_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  push,
    output logic  full,
    input  logic  [1:0] i_req_type,
    input  t_pos  i_first_pos,
    input  t_pos  i_second_pos,
    input  logic  i_cmd_pop,
    output logic  o_cmd_valid,
    output t_cmd  o_cmd
);

    localparam int DEPTH = 2;

    t_cmd       r_q [DEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       w_cmd;
    t_op        w_op;
    logic       w_in1;
    logic       w_in2;
    logic       w_wr_en;
    logic       w_rd_en;

    // classify: range check, equal positions, order the span ends
    always_comb begin
        w_op  = t_op'(i_req_type);
        w_in1 = pos_ext(i_first_pos) < EXT_W'(NUM_CITIES);
        w_in2 = pos_ext(i_second_pos) < EXT_W'(NUM_CITIES);
        w_cmd.op = w_op;
        if (w_op == OP_READ) begin
            w_cmd.reject = !w_in1;
        end else begin
            w_cmd.reject = !w_in1 || !w_in2 || (i_first_pos == i_second_pos);
        end
        if (w_op inside {OP_SWAP, OP_READ} || i_first_pos < i_second_pos) begin
            w_cmd.lo = t_idx'(pos_ext(i_first_pos));
            w_cmd.hi = t_idx'(pos_ext(i_second_pos));
        end else begin
            w_cmd.lo = t_idx'(pos_ext(i_second_pos));
            w_cmd.hi = t_idx'(pos_ext(i_first_pos));
        end
    end

    assign full        = (r_cnt == 2'(DEPTH));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign w_wr_en     = push && !full;
    assign w_rd_en     = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr_en && !w_rd_en) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_wr_en && w_rd_en) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr_en) begin
                r_wr <= !r_wr;
            end
            if (w_rd_en) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

@@ hw/rtl/tpme_back.sv @@
module tpme_back
    import tpme_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    input  logic pop,
    output logic empty,
    output t_res o_res
);

    localparam int DEPTH = 2;

    t_state     r_state;
    t_state     n_state;
    t_op        r_op;
    t_op        n_op;
    t_idx       r_lo;
    t_idx       n_lo;
    t_idx       r_hi;
    t_idx       n_hi;
    logic       r_status;
    logic       n_status;
    t_mem_req   w_mem;
    t_idx       w_rd_a;
    t_idx       w_rd_b;
    logic       w_res_push;
    t_res       w_res;

    t_res       r_rq [DEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_res_full;
    logic       w_rd_en;

    tpme_tour_mem u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_mem),
        .o_data_a (w_rd_a),
        .o_data_b (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_status <= n_status;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_status   = r_status;
        o_cmd_pop  = 1'b0;
        w_res_push = 1'b0;
        w_mem      = '0;
        w_res.status = r_status;
        w_res.city   = (r_op == OP_READ && !r_status) ? city_field(w_rd_a) : '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_op      = i_cmd.op;
                    n_lo      = i_cmd.lo;
                    n_hi      = i_cmd.hi;
                    n_status  = i_cmd.reject;
                    if (i_cmd.reject) begin
                        n_state = S_DONE;
                    end else begin
                        w_mem.re_a   = 1'b1;
                        w_mem.addr_a = i_cmd.lo;
                        w_mem.re_b   = (i_cmd.op != OP_READ);
                        w_mem.addr_b = (i_cmd.op == OP_ROTATE) ?
                                       t_idx'(i_cmd.lo + 1'b1) : i_cmd.hi;
                        case (i_cmd.op)
                            OP_READ:   n_state = S_DONE;
                            OP_ROTATE: n_state = S_SHIFT;
                            default:   n_state = S_WLO;
                        endcase
                    end
                end
            end
            S_WLO: begin
                w_mem.we    = 1'b1;
                w_mem.waddr = r_lo;
                w_mem.wdata = w_rd_b;
                n_state     = S_WHI;
            end
            S_WHI: begin
                w_mem.we    = 1'b1;
                w_mem.waddr = r_hi;
                w_mem.wdata = w_rd_a;
                // next inner pair read while this one is written back
                if (r_op == OP_REVERSE &&
                    ((IDX_W+1)'(r_lo) + (IDX_W+1)'(2) < (IDX_W+1)'(r_hi))) begin
                    w_mem.re_a   = 1'b1;
                    w_mem.addr_a = t_idx'(r_lo + 1'b1);
                    w_mem.re_b   = 1'b1;
                    w_mem.addr_b = t_idx'(r_hi - 1'b1);
                    n_lo         = t_idx'(r_lo + 1'b1);
                    n_hi         = t_idx'(r_hi - 1'b1);
                    n_state      = S_WLO;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                // port a holds the segment head, port b the next entry up
                w_mem.we    = 1'b1;
                w_mem.waddr = r_lo;
                w_mem.wdata = w_rd_b;
                if ((IDX_W+1)'(r_lo) + (IDX_W+1)'(1) == (IDX_W+1)'(r_hi)) begin
                    n_state = S_TAIL;
                end else begin
                    w_mem.re_b   = 1'b1;
                    w_mem.addr_b = t_idx'(r_lo + 2'd2);
                    n_lo         = t_idx'(r_lo + 1'b1);
                end
            end
            S_TAIL: begin
                w_mem.we    = 1'b1;
                w_mem.waddr = r_hi;
                w_mem.wdata = w_rd_a;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!w_res_full) begin
                    w_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result queue
    assign w_res_full = (r_cnt == 2'(DEPTH));
    assign empty      = (r_cnt == 2'd0);
    assign o_res      = r_rq[r_rd];
    assign w_rd_en    = pop && !empty;

    always_comb begin
        n_cnt = r_cnt;
        if (w_res_push && !w_rd_en) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_res_push && w_rd_en) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_res_push) begin
                r_wr <= !r_wr;
            end
            if (w_rd_en) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_rq[r_wr] <= w_res;
        end
    end

endmodule

@@ hw/rtl/tour_permutation_move_engine.sv @@
// requests wait in the front queue while the back is busy; the back finishes one request before it
// takes the next, paced by the single write port of the tour memory
// reset: synchronous, active low; both queues empty, the tour reads as the identity
// right after reset (per-entry valid bits, no clearing pass)
module tour_permutation_move_engine
    import tpme_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_req_type,
    input  logic [5:0] i_first_pos,
    input  logic [5:0] i_second_pos,
    output logic       empty,
    input  logic       pop,
    output logic [5:0] o_city,
    output logic       o_status
);

    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_cmd;
    t_res w_res;

    // front: takes the request transfer, range and equality checks, orders the span,
    // and holds classified commands in a two-entry queue
    tpme_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_first_pos  (i_first_pos),
        .i_second_pos (i_second_pos),
        .i_cmd_pop    (w_cmd_pop),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd)
    );

    // back: sequencer over the tour memory, at most one write per cycle; swap and reverse
    // read a pair and write it back crossed, rotate shifts one entry per cycle
    tpme_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .pop         (pop),
        .empty       (empty),
        .o_res       (w_res)
    );

    // result transfer fields
    assign o_city   = w_res.city;
    assign o_status = w_res.status;

    // the back never takes a command from an empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("command taken from empty queue");

    // a rejected request never reports a city
    a_reject_city: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status) |-> (o_city == 6'd0))
        else $error("rejected request with nonzero city");

    // no result can be waiting right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> empty)
        else $error("result present right after reset");

endmodule
